@@ hdl/lfpd_pkg.sv @@
// Package for the line follower PID drive unit: field widths, register
// indexes, direction codes, reset values and the sensor pattern table.
// No dependencies.
package lfpd_pkg;

  localparam int PatternWidth = 5;
  localparam int DutyWidth    = 8;
  localparam int ErrorWidth   = 4;
  localparam int DirWidth     = 2;
  localparam int CorrWidth    = 25;
  localparam int CfgIdxWidth  = 3;
  localparam int CfgDataWidth = 8;

  localparam int IntegralBitsDefault = 16;

  localparam logic [CfgIdxWidth-1:0] RegGainP      = 3'd0;
  localparam logic [CfgIdxWidth-1:0] RegGainI      = 3'd1;
  localparam logic [CfgIdxWidth-1:0] RegGainD      = 3'd2;
  localparam logic [CfgIdxWidth-1:0] RegBaseSpeed  = 3'd3;
  localparam logic [CfgIdxWidth-1:0] RegSpeedLimit = 3'd4;

  localparam logic [DutyWidth-1:0] GainPReset      = 8'd8;
  localparam logic [DutyWidth-1:0] GainIReset      = 8'd0;
  localparam logic [DutyWidth-1:0] GainDReset      = 8'd8;
  localparam logic [DutyWidth-1:0] BaseSpeedReset  = 8'd120;
  localparam logic [DutyWidth-1:0] SpeedLimitReset = 8'd155;

  localparam logic [DirWidth-1:0] DirStraight = 2'd0;
  localparam logic [DirWidth-1:0] DirLeft     = 2'd1;
  localparam logic [DirWidth-1:0] DirRight    = 2'd2;

  localparam logic signed [CorrWidth-1:0] CorrMax = 25'sh0FFFFFF;
  localparam logic signed [CorrWidth-1:0] CorrMin = -25'sh1000000;

  localparam logic [PatternWidth-1:0] PatAllWhite = 5'h00;

  typedef struct packed {
    logic                         hit;
    logic signed [ErrorWidth-1:0] err;
  } pat_map_t;

  function automatic pat_map_t map_pattern(input logic [PatternWidth-1:0] pat);
    pat_map_t m;
    m.hit = 1'b1;
    m.err = '0;
    unique case (pat)
      5'h10:   m.err = 4'sd4;
      5'h18:   m.err = 4'sd3;
      5'h08:   m.err = 4'sd2;
      5'h0C:   m.err = 4'sd1;
      5'h04:   m.err = 4'sd0;
      5'h06:   m.err = -4'sd1;
      5'h02:   m.err = -4'sd2;
      5'h03:   m.err = -4'sd3;
      5'h01:   m.err = -4'sd4;
      default: m.hit = 1'b0;
    endcase
    return m;
  endfunction

endpackage

@@ hdl/line_follow_pid_drive_unit.sv @@
// Line follower PID drive unit: input register, PID datapath, result register.
// Depends on lfpd_pkg.
// Path: an accepted beat waits in the input register and moves into the result
// register once that register is empty or its output is not stalled.
// Throughput: one beat per cycle while out_stall is not held; the single PID
// pass between the input and result registers sets this figure.
// Reset: synchronous, active high; clears held error, last error, integral,
// both valids, and loads the register defaults.
module line_follow_pid_drive_unit
  import lfpd_pkg::*;
#(
  parameter int INTEGRAL_BITS = IntegralBitsDefault
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [CfgIdxWidth-1:0]         cfg_index,
  input  logic [CfgDataWidth-1:0]        cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [PatternWidth-1:0]        sensor_pattern,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [DutyWidth-1:0]           left_speed,
  output logic [DutyWidth-1:0]           right_speed,
  output logic [DirWidth-1:0]            direction,
  output logic                           line_lost,
  output logic signed [ErrorWidth-1:0]   position_error,
  output logic signed [CorrWidth-1:0]    correction
);

  localparam int IB     = INTEGRAL_BITS;
  localparam int ProdIW = IB + 9;
  localparam int PidW   = (IB + 11 > CorrWidth + 1) ? IB + 11 : CorrWidth + 1;
  localparam int SpdW   = CorrWidth + 2;

  logic [DutyWidth-1:0] gain_p, gain_i, gain_d, base_speed, speed_limit;

  logic                         held_valid;
  logic [PatternWidth-1:0]      held_pattern;
  logic signed [ErrorWidth-1:0] held_error, held_error_next;
  logic signed [ErrorWidth-1:0] last_error;
  logic signed [IB-1:0]         integral_sum, integral_sum_next;

  logic advance, accept;
  pat_map_t pm;

  logic signed [IB:0]         integ_raw;
  logic signed [12:0]         prod_p;
  logic signed [ProdIW-1:0]   prod_i;
  logic signed [ErrorWidth:0] err_diff;
  logic signed [13:0]         prod_d;
  logic signed [PidW-1:0]     pid_full;
  logic signed [CorrWidth-1:0] pid_sat;
  logic signed [SpdW-1:0]     base_ext, lim_ext, left_raw, right_raw;
  logic [DutyWidth-1:0]       left_next, right_next;
  logic [DirWidth-1:0]        dir_next;

  assign advance  = held_valid && (!out_valid || !out_stall);
  assign in_stall = held_valid && !advance;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p      <= GainPReset;
      gain_i      <= GainIReset;
      gain_d      <= GainDReset;
      base_speed  <= BaseSpeedReset;
      speed_limit <= SpeedLimitReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegGainP:      gain_p      <= cfg_data;
        RegGainI:      gain_i      <= cfg_data;
        RegGainD:      gain_d      <= cfg_data;
        RegBaseSpeed:  base_speed  <= cfg_data;
        RegSpeedLimit: speed_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    pm              = map_pattern(held_pattern);
    held_error_next = pm.hit ? pm.err : held_error;

    integ_raw = (IB+1)'(integral_sum) + (IB+1)'(held_error_next);
    if (integ_raw[IB] != integ_raw[IB-1]) begin
      integral_sum_next = integ_raw[IB] ? {1'b1, {(IB-1){1'b0}}} : {1'b0, {(IB-1){1'b1}}};
    end else begin
      integral_sum_next = integ_raw[IB-1:0];
    end

    err_diff = (ErrorWidth+1)'(held_error_next) - (ErrorWidth+1)'(last_error);
    prod_p   = $signed({1'b0, gain_p}) * held_error_next;
    prod_i   = $signed({1'b0, gain_i}) * integral_sum_next;
    prod_d   = $signed({1'b0, gain_d}) * err_diff;
    pid_full = PidW'(prod_p) + PidW'(prod_i) + PidW'(prod_d);

    priority if (pid_full > PidW'(CorrMax)) begin
      pid_sat = CorrMax;
    end else if (pid_full < PidW'(CorrMin)) begin
      pid_sat = CorrMin;
    end else begin
      pid_sat = pid_full[CorrWidth-1:0];
    end

    base_ext  = $signed({{(SpdW-DutyWidth){1'b0}}, base_speed});
    lim_ext   = $signed({{(SpdW-DutyWidth){1'b0}}, speed_limit});
    left_raw  = base_ext - SpdW'(pid_sat);
    right_raw = base_ext + SpdW'(pid_sat);

    priority if (left_raw < 0) begin
      left_next = '0;
    end else if (left_raw > lim_ext) begin
      left_next = speed_limit;
    end else begin
      left_next = left_raw[DutyWidth-1:0];
    end

    priority if (right_raw < 0) begin
      right_next = '0;
    end else if (right_raw > lim_ext) begin
      right_next = speed_limit;
    end else begin
      right_next = right_raw[DutyWidth-1:0];
    end

    priority if (held_error_next == 0) begin
      dir_next = DirStraight;
    end else if (held_error_next < 0) begin
      dir_next = DirLeft;
    end else begin
      dir_next = DirRight;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid   <= 1'b0;
      out_valid    <= 1'b0;
      held_error   <= '0;
      last_error   <= '0;
      integral_sum <= '0;
    end else begin
      if (accept) begin
        held_valid <= 1'b1;
      end else if (advance) begin
        held_valid <= 1'b0;
      end
      if (advance) begin
        out_valid    <= 1'b1;
        held_error   <= held_error_next;
        last_error   <= held_error_next;
        integral_sum <= integral_sum_next;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_pattern <= sensor_pattern;
    end
    if (advance) begin
      left_speed     <= left_next;
      right_speed    <= right_next;
      direction      <= dir_next;
      line_lost      <= (held_pattern == PatAllWhite);
      position_error <= held_error_next;
      correction     <= pid_sat;
    end
  end

endmodule
